/* rtl/blint_pkg.sv */
// ----------------------------------------------------------------------------
// blint_pkg: shared constants, types and helpers
// Table geometry, register indexes, mode codes, pipeline payload types and the
// single step of the breakpoint upper-bound search.
// ----------------------------------------------------------------------------
package blint_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int LEVELS      = ADDR_W + 1;
	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int IDX_W       = 8;
	localparam int NIN_W       = 9;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int PROD_W      = DATA_W + 1 + FRAC_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OOR_MODE    = 3'd0,
		REG_INTERP_MODE = 3'd1,
		REG_LOW_FILL    = 3'd2,
		REG_HIGH_FILL   = 3'd3,
		REG_ENTRIES     = 3'd4,
		REG_USE_BP      = 3'd5
	} cfg_reg_t;

	localparam logic [MODE_W-1:0] OOR_CLAMP      = 2'd0;
	localparam logic [MODE_W-1:0] OOR_FILL       = 2'd1;
	localparam logic [MODE_W-1:0] OOR_PASS       = 2'd2;
	localparam logic [MODE_W-1:0] INTERP_LINEAR  = 2'd0;
	localparam logic [MODE_W-1:0] INTERP_NEAREST = 2'd1;

	// item payload through the read part of the pipeline
	typedef struct packed {
		logic                     lookup;
		logic                     wen;
		logic signed [DATA_W-1:0] sample;
		logic [IDX_W-1:0]         widx;
		logic [DATA_W-1:0]        wbp;
		logic [DATA_W-1:0]        wval;
		logic                     below;
		logic                     above;
	} pipe_t;

	typedef struct packed {
		logic [CNT_W-1:0]  first;
		logic [CNT_W-1:0]  count;
		logic [ADDR_W-1:0] probe;
	} srch_t;

	typedef struct packed {
		logic [CNT_W-1:0] first;
		logic [CNT_W-1:0] count;
	} bounds_t;

	// payload through the divider and interpolation part
	typedef struct packed {
		logic                     lookup;
		logic                     lerp;
		logic                     use_div;
		logic [FRAC_W-1:0]        fdir;
		logic [DATA_W-1:0]        rem;
		logic [DATA_W-1:0]        den;
		logic [FRAC_W-1:0]        q;
		logic signed [DATA_W-1:0] v0;
		logic signed [DATA_W:0]   dv;
		logic [DATA_W-1:0]        fixed;
	} div_t;

	// one step of the upper-bound search: probe was first + count/2
	function automatic bounds_t search_update(srch_t st, logic signed [DATA_W-1:0] s,
			logic signed [DATA_W-1:0] bp);
		bounds_t b;
		logic [CNT_W-1:0] step;
		step    = st.count >> 1;
		b.first = st.first;
		b.count = st.count;
		if (st.count != '0) begin
			if (!(s < bp)) begin
				b.first = CNT_W'(st.probe) + CNT_W'(1);
				b.count = st.count - step - CNT_W'(1);
			end else begin
				b.count = step;
			end
		end
		return b;
	endfunction

endpackage

/* rtl/blint_ram.sv */
// ----------------------------------------------------------------------------
// blint_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module blint_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/blint_level.sv */
// ----------------------------------------------------------------------------
// blint_level: one level of the breakpoint search
// Issue the probe read into a private copy of the breakpoint store and
// register the item and search bounds alongside the read data.
// ----------------------------------------------------------------------------
module blint_level (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          vld_in,
	input  blint_pkg::pipe_t              p_in,
	input  logic [blint_pkg::CNT_W-1:0]   first_in,
	input  logic [blint_pkg::CNT_W-1:0]   count_in,
	output logic                          vld_out,
	output blint_pkg::pipe_t              p_out,
	output blint_pkg::srch_t              s_out,
	output logic [blint_pkg::DATA_W-1:0]  bp_out
);
	import blint_pkg::*;

	logic [ADDR_W-1:0] probe;

	assign probe = ADDR_W'(first_in + (count_in >> 1));

	blint_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (adv && vld_in && p_in.wen),
		.waddr(ADDR_W'(p_in.widx)),
		.wdata(p_in.wbp),
		.re   (adv),
		.raddr(probe),
		.rdata(bp_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_out       <= p_in;
			s_out.first <= first_in;
			s_out.count <= count_in;
			s_out.probe <= probe;
		end
	end

endmodule

/* rtl/blint_div.sv */
// ----------------------------------------------------------------------------
// blint_div: one restoring division step
// Produce one fraction bit of (num << 16) / den per stage.
// ----------------------------------------------------------------------------
module blint_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_in,
	input  blint_pkg::div_t  d_in,
	output logic             vld_out,
	output blint_pkg::div_t  d_out
);
	import blint_pkg::*;

	logic [DATA_W:0] r2;
	logic            ge;
	div_t            nd;

	always_comb begin
		r2 = {d_in.rem, 1'b0};
		ge = r2 >= {1'b0, d_in.den};
		nd = d_in;
		if (d_in.use_div) begin
			nd.rem = ge ? DATA_W'(r2 - {1'b0, d_in.den}) : r2[DATA_W-1:0];
			nd.q   = {d_in.q[FRAC_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_out <= nd;
		end
	end

endmodule

/* rtl/breakpoint_lut_interpolator.sv */
// ----------------------------------------------------------------------------
// breakpoint_lut_interpolator: Q16.16 piecewise-linear table lookup
// Path: a lookup passes through the input stage, 9 search levels (256-entry
// table), value read, 16 divider steps, multiply and output register.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset clears valid bits and configuration (entries_in_use to 256); table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module breakpoint_lut_interpolator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [blint_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [blint_pkg::DATA_W-1:0] entry_breakpoint,
	input  logic signed [blint_pkg::DATA_W-1:0] entry_value,
	input  logic signed [blint_pkg::DATA_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [blint_pkg::DATA_W-1:0] result_value,
	input  logic                                cfg_we,
	input  logic [blint_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [blint_pkg::DATA_W-1:0]        cfg_wdata
);
	import blint_pkg::*;

	// configuration registers
	logic [MODE_W-1:0] oor_q;
	logic [MODE_W-1:0] interp_q;
	logic [DATA_W-1:0] low_fill_q;
	logic [DATA_W-1:0] high_fill_q;
	logic [NIN_W-1:0]  entries_q;
	logic              use_bp_q;

	logic [CNT_W-1:0]  n_ent;
	logic [ADDR_W-1:0] last;

	// global advance: the pipeline moves whenever the output slot frees up
	logic adv;

	logic  vld_s1;
	pipe_t pipe_s1;
	pipe_t in_pipe;

	logic [DATA_W-1:0] lo_rd, hi_rd;

	logic  lv_out [LEVELS];
	pipe_t lp_out [LEVELS];
	srch_t ls_out [LEVELS];
	logic [DATA_W-1:0] lb_out [LEVELS];
	pipe_t lp_in  [LEVELS];
	logic  lv_in  [LEVELS];
	logic [CNT_W-1:0] lf_in [LEVELS];
	logic [CNT_W-1:0] lc_in [LEVELS];

	pipe_t pipe_s2f;

	// last search level output (s10) and the table reads it issues
	logic              vld_s10;
	pipe_t             pipe_s10;
	bounds_t           fin_s10;
	logic [ADDR_W-1:0] k_s10;
	logic [ADDR_W-1:0] idx_s10;
	logic [CNT_W-1:0]  rnd_s10;
	logic [ADDR_W-1:0] av0_s10, av1_s10;

	logic              vld_s11;
	pipe_t             pipe_s11;
	logic [ADDR_W-1:0] k_s11;
	logic [DATA_W-1:0] b0_rd, b1_rd, v0_rd, v1_rd;

	div_t d0;
	logic signed [DATA_W:0] num, den, nb;

	logic dv_v [FRAC_W+1];
	div_t dv_d [FRAC_W+1];

	logic [FRAC_W-1:0]        f_sel;
	logic signed [PROD_W-1:0] prod;
	logic                     vld_s28;
	logic                     lookup_s28;
	logic                     lerp_s28;
	logic signed [PROD_W-1:0] p_s28;
	logic signed [DATA_W-1:0] v0_s28;
	logic [DATA_W-1:0]        fixed_s28;
	logic signed [PROD_W-1:0] p_sh;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        result_q;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_q       <= OOR_CLAMP;
			interp_q    <= INTERP_LINEAR;
			low_fill_q  <= '0;
			high_fill_q <= '0;
			entries_q   <= NIN_W'(256);
			use_bp_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OOR_MODE:    oor_q       <= cfg_wdata[MODE_W-1:0];
				REG_INTERP_MODE: interp_q    <= cfg_wdata[MODE_W-1:0];
				REG_LOW_FILL:    low_fill_q  <= cfg_wdata;
				REG_HIGH_FILL:   high_fill_q <= cfg_wdata;
				REG_ENTRIES:     entries_q   <= cfg_wdata[NIN_W-1:0];
				REG_USE_BP:      use_bp_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective entry count: zero acts as one, clip at the table depth
	always_comb begin
		if (entries_q == '0) begin
			n_ent = CNT_W'(1);
		end else if (32'(entries_q) > TABLE_DEPTH) begin
			n_ent = CNT_W'(TABLE_DEPTH);
		end else begin
			n_ent = CNT_W'(entries_q);
		end
		last = ADDR_W'(n_ent - CNT_W'(1));
	end

	// ------------------------------------------------------------------
	// handshake and input stage
	// ------------------------------------------------------------------
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign result_value = result_q;

	always_comb begin
		in_pipe.lookup = func;
		in_pipe.wen    = !func && (32'(entry_index) < TABLE_DEPTH);
		in_pipe.sample = sample;
		in_pipe.widx   = entry_index;
		in_pipe.wbp    = entry_breakpoint;
		in_pipe.wval   = entry_value;
		in_pipe.below  = 1'b0;
		in_pipe.above  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			pipe_s1 <= in_pipe;
		end
	end

	// range ends of the breakpoint table: first entry and last entry in use
	blint_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_lo_ram (
		.clk  (clk),
		.we   (adv && vld_s1 && pipe_s1.wen),
		.waddr(ADDR_W'(pipe_s1.widx)),
		.wdata(pipe_s1.wbp),
		.re   (adv),
		.raddr('0),
		.rdata(lo_rd)
	);

	blint_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_hi_ram (
		.clk  (clk),
		.we   (adv && vld_s1 && pipe_s1.wen),
		.waddr(ADDR_W'(pipe_s1.widx)),
		.wdata(pipe_s1.wbp),
		.re   (adv),
		.raddr(last),
		.rdata(hi_rd)
	);

	// ------------------------------------------------------------------
	// s2: range check, merged into the item as it enters level 1
	// ------------------------------------------------------------------
	always_comb begin
		pipe_s2f = lp_out[0];
		if (use_bp_q) begin
			pipe_s2f.below = lp_out[0].sample < $signed(lo_rd);
			pipe_s2f.above = lp_out[0].sample > $signed(hi_rd);
		end else begin
			pipe_s2f.below = lp_out[0].sample[DATA_W-1];
			pipe_s2f.above = !lp_out[0].sample[DATA_W-1] &&
				(unsigned'(lp_out[0].sample) > (32'(last) << FRAC_W));
		end
	end

	// ------------------------------------------------------------------
	// search levels: each level owns a copy of the breakpoint store; each
	// level after the first takes the bounds updated with the previous
	// level's probe result
	for (genvar j = 0; j < LEVELS; j++) begin : g_level
		if (j == 0) begin : g_first
			assign lp_in[j] = pipe_s1;
			assign lv_in[j] = vld_s1;
			assign lf_in[j] = '0;
			assign lc_in[j] = n_ent;
		end else begin : g_next
			bounds_t upd;
			assign upd      = search_update(ls_out[j-1], lp_out[j-1].sample,
				$signed(lb_out[j-1]));
			assign lp_in[j] = (j == 1) ? pipe_s2f : lp_out[j-1];
			assign lv_in[j] = lv_out[j-1];
			assign lf_in[j] = upd.first;
			assign lc_in[j] = upd.count;
		end

		blint_level u_level (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (lv_in[j]),
			.p_in    (lp_in[j]),
			.first_in(lf_in[j]),
			.count_in(lc_in[j]),
			.vld_out (lv_out[j]),
			.p_out   (lp_out[j]),
			.s_out   (ls_out[j]),
			.bp_out  (lb_out[j])
		);
	end

	// ------------------------------------------------------------------
	// s10: final search step and table addresses for the value reads
	// ------------------------------------------------------------------
	assign vld_s10  = lv_out[LEVELS-1];
	assign pipe_s10 = lp_out[LEVELS-1];
	assign fin_s10  = search_update(ls_out[LEVELS-1], pipe_s10.sample,
		$signed(lb_out[LEVELS-1]));

	always_comb begin
		k_s10   = (fin_s10.first == '0) ? '0 : ADDR_W'(fin_s10.first - CNT_W'(1));
		idx_s10 = ADDR_W'(unsigned'(pipe_s10.sample) >> FRAC_W);
		rnd_s10 = CNT_W'(idx_s10) + CNT_W'(pipe_s10.sample[FRAC_W-1]);
		av0_s10 = idx_s10;
		av1_s10 = idx_s10 + ADDR_W'(1);
		if (pipe_s10.below) begin
			av0_s10 = '0;
		end else if (pipe_s10.above) begin
			av0_s10 = last;
		end else if (use_bp_q) begin
			av0_s10 = k_s10;
			av1_s10 = k_s10 + ADDR_W'(1);
		end else if (interp_q == INTERP_NEAREST) begin
			// round half up, never past the last entry
			av0_s10 = (rnd_s10 > CNT_W'(last)) ? last : ADDR_W'(rnd_s10);
		end
	end

	blint_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_b0_ram (
		.clk  (clk),
		.we   (adv && vld_s10 && pipe_s10.wen),
		.waddr(ADDR_W'(pipe_s10.widx)),
		.wdata(pipe_s10.wbp),
		.re   (adv),
		.raddr(k_s10),
		.rdata(b0_rd)
	);

	blint_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_b1_ram (
		.clk  (clk),
		.we   (adv && vld_s10 && pipe_s10.wen),
		.waddr(ADDR_W'(pipe_s10.widx)),
		.wdata(pipe_s10.wbp),
		.re   (adv),
		.raddr(k_s10 + ADDR_W'(1)),
		.rdata(b1_rd)
	);

	blint_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_v0_ram (
		.clk  (clk),
		.we   (adv && vld_s10 && pipe_s10.wen),
		.waddr(ADDR_W'(pipe_s10.widx)),
		.wdata(pipe_s10.wval),
		.re   (adv),
		.raddr(av0_s10),
		.rdata(v0_rd)
	);

	blint_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_v1_ram (
		.clk  (clk),
		.we   (adv && vld_s10 && pipe_s10.wen),
		.waddr(ADDR_W'(pipe_s10.widx)),
		.wdata(pipe_s10.wval),
		.re   (adv),
		.raddr(av1_s10),
		.rdata(v1_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s11 <= pipe_s10;
			k_s11    <= k_s10;
		end
	end

	// ------------------------------------------------------------------
	// s11: pick the result kind; either a ready value or an interpolation
	// ------------------------------------------------------------------
	always_comb begin
		num = $signed({pipe_s11.sample[DATA_W-1], pipe_s11.sample})
			- $signed({b0_rd[DATA_W-1], b0_rd});
		den = $signed({b1_rd[DATA_W-1], b1_rd}) - $signed({b0_rd[DATA_W-1], b0_rd});
		nb  = $signed({b1_rd[DATA_W-1], b1_rd})
			- $signed({pipe_s11.sample[DATA_W-1], pipe_s11.sample});

		d0.lookup  = pipe_s11.lookup;
		d0.lerp    = 1'b0;
		d0.use_div = 1'b0;
		d0.fdir    = pipe_s11.sample[FRAC_W-1:0];
		d0.rem     = num[DATA_W-1:0];
		d0.den     = den[DATA_W-1:0];
		d0.q       = '0;
		d0.v0      = $signed(v0_rd);
		d0.dv      = $signed({v1_rd[DATA_W-1], v1_rd}) - $signed({v0_rd[DATA_W-1], v0_rd});
		d0.fixed   = v0_rd;

		if (pipe_s11.below || pipe_s11.above) begin
			if (oor_q == OOR_FILL) begin
				d0.fixed = pipe_s11.below ? low_fill_q : high_fill_q;
			end else if (oor_q == OOR_PASS) begin
				d0.fixed = pipe_s11.sample;
			end
		end else if (use_bp_q) begin
			if (pipe_s11.sample == $signed(b0_rd) ||
					(CNT_W'(k_s11) + CNT_W'(1)) >= n_ent) begin
				d0.fixed = v0_rd;
			end else if (interp_q == INTERP_LINEAR) begin
				if (num <= 0) begin
					d0.fixed = v0_rd;
				end else if (den <= num) begin
					// fraction saturates: take the upper entry
					d0.fixed = v1_rd;
				end else begin
					d0.lerp    = 1'b1;
					d0.use_div = 1'b1;
				end
			end else if (interp_q == INTERP_NEAREST && num > nb) begin
				d0.fixed = v1_rd;
			end
		end else if (interp_q == INTERP_LINEAR && pipe_s11.sample[FRAC_W-1:0] != '0) begin
			d0.lerp = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// fraction divider: one quotient bit per stage
	// ------------------------------------------------------------------
	assign dv_v[0] = vld_s11;
	assign dv_d[0] = d0;

	for (genvar i = 0; i < FRAC_W; i++) begin : g_div
		blint_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_in (dv_v[i]),
			.d_in   (dv_d[i]),
			.vld_out(dv_v[i+1]),
			.d_out  (dv_d[i+1])
		);
	end

	// ------------------------------------------------------------------
	// multiply: (v1 - v0) * f
	// ------------------------------------------------------------------
	assign f_sel = dv_d[FRAC_W].use_div ? dv_d[FRAC_W].q : dv_d[FRAC_W].fdir;
	assign prod  = dv_d[FRAC_W].dv * $signed({1'b0, f_sel});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s28 <= 1'b0;
		end else if (adv) begin
			vld_s28 <= dv_v[FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lookup_s28 <= dv_d[FRAC_W].lookup;
			lerp_s28   <= dv_d[FRAC_W].lerp;
			p_s28      <= prod;
			v0_s28     <= dv_d[FRAC_W].v0;
			fixed_s28  <= dv_d[FRAC_W].fixed;
		end
	end

	// ------------------------------------------------------------------
	// output register: v0 + floor(prod / 65536) or the ready value; drop loads here
	// ------------------------------------------------------------------
	assign p_sh = p_s28 >>> FRAC_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s28 && lookup_s28;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= lerp_s28 ? DATA_W'(v0_s28 + p_sh[DATA_W-1:0]) : fixed_s28;
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 |-> (fin_s10.first <= n_ent))
		else $error("search index ran past the entries in use");

	a_div_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s11 && d0.use_div) |-> (d0.rem < d0.den && d0.rem != '0))
		else $error("divider started with a fraction outside (0,1)");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s28 && lookup_s28 && out_valid_q && !out_ready) |=> vld_s28)
		else $error("pipeline item lost under output stall");

endmodule

/* dv/tb_breakpoint_lut_interpolator.sv */
// ----------------------------------------------------------------------------
// tb_breakpoint_lut_interpolator: self-checking bench for the table interpolator
// Fills the whole table, walks a directed table of config writes, loads and
// lookups, then runs random config phases. In breakpoint mode most phases load
// sorted tables before the lookups. Every lookup result is checked in order
// against a behavioral mapping of the sample, or against a value typed into a
// directed row, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_breakpoint_lut_interpolator;
	timeunit 1ns;
	timeprecision 1ps;

	import blint_pkg::*;

	localparam logic              FUNC_LOAD     = 1'b0;
	localparam logic              FUNC_LOOKUP   = 1'b1;
	localparam logic [MODE_W-1:0] OOR_UNUSED    = 2'd3;
	localparam logic [MODE_W-1:0] INTERP_HOLD   = 2'd2;
	localparam logic [MODE_W-1:0] INTERP_UNUSED = 2'd3;
	localparam int                SETTLE_CYCLES = 40;   // beyond the pipeline latency
	localparam int                STALL_LIMIT   = 5000; // cycles without any transfer
	localparam int                LONG_HOLD     = 500;
	localparam int                PHASES        = 5;
	localparam int                PHASE_LOOKUPS = 30;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     func;
	logic [IDX_W-1:0]         entry_index;
	logic signed [DATA_W-1:0] entry_breakpoint;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] sample;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] result_value;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]        cfg_wdata;

	breakpoint_lut_interpolator DUT (.*);

	// mirrored table contents and configuration
	logic signed [DATA_W-1:0] bp_mem  [TABLE_DEPTH];
	logic signed [DATA_W-1:0] val_mem [TABLE_DEPTH];
	logic [MODE_W-1:0]        oor_sel;
	logic [MODE_W-1:0]        interp_sel;
	logic signed [DATA_W-1:0] fill_lo;
	logic signed [DATA_W-1:0] fill_hi;
	logic [NIN_W-1:0]         entry_cnt;
	logic                     bp_search;

	logic signed [DATA_W-1:0] pending_results [$];
	int errors;
	int results_seen;
	int burst_left;

	typedef enum {ROW_CFG, ROW_LOAD, ROW_LOOK} row_kind_t;
	typedef struct {
		row_kind_t         kind;
		cfg_reg_t          reg_sel;
		logic [DATA_W-1:0] data;   // cfg data, breakpoint or sample
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
		bit                typed;  // expected value typed into the row
		logic [DATA_W-1:0] exp_val;
	} dir_row_t;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// --- behavioral mapping of one sample ---------------------------------
	function automatic int active_entries();
		int n;
		n = entry_cnt;
		if (n == 0) n = 1;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		return n;
	endfunction

	function automatic longint lerp_q16(longint v0, longint v1, longint f);
		return v0 + (((v1 - v0) * f) >>> 16);
	endfunction

	function automatic logic [DATA_W-1:0] map_sample(logic signed [DATA_W-1:0] smp);
		longint s, lo, hi, r, b0, b1, num, den, f;
		int n, last, first, count, step, probe, k, idx;
		n    = active_entries();
		last = n - 1;
		s    = smp;
		if (bp_search) begin
			lo = bp_mem[0];
			hi = bp_mem[last];
		end else begin
			lo = 0;
			hi = longint'(last) * 65536;
		end
		if (s < lo || s > hi) begin
			if (oor_sel == OOR_FILL) r = (s < lo) ? fill_lo : fill_hi;
			else if (oor_sel == OOR_PASS) r = s;
			else r = (s < lo) ? val_mem[0] : val_mem[last];
		end else if (!bp_search) begin
			idx = int'(s >>> 16);
			f   = s & 64'hFFFF;
			if (interp_sel == INTERP_LINEAR) begin
				r = (f == 0) ? val_mem[idx] : lerp_q16(val_mem[idx], val_mem[idx + 1], f);
			end else begin
				if (interp_sel == INTERP_NEAREST) begin
					idx = int'((s + 32768) >>> 16);
					if (idx > last) idx = last;
				end
				r = val_mem[idx];
			end
		end else begin
			// upper-bound search: first entry whose breakpoint is above the sample
			first = 0;
			count = n;
			while (count > 0) begin
				step  = count / 2;
				probe = first + step;
				if (!(s < longint'(bp_mem[probe]))) begin
					first = probe + 1;
					count = count - step - 1;
				end else begin
					count = step;
				end
			end
			k  = (first == 0) ? 0 : first - 1;
			b0 = bp_mem[k];
			if (s == b0 || k + 1 >= n) begin
				r = val_mem[k];
			end else begin
				b1 = bp_mem[k + 1];
				if (interp_sel == INTERP_LINEAR) begin
					num = s - b0;
					den = b1 - b0;
					if (den <= num || num <= 0) begin
						r = (num <= 0) ? val_mem[k] : val_mem[k + 1];
					end else begin
						f = (num << 16) / den;
						r = lerp_q16(val_mem[k], val_mem[k + 1], f);
					end
				end else if (interp_sel == INTERP_NEAREST && (s - b0) > (b1 - s)) begin
					r = val_mem[k + 1];
				end else begin
					r = val_mem[k];
				end
			end
		end
		return r[DATA_W-1:0];
	endfunction

	// --- sender -------------------------------------------------------------
	// Called at a clock edge; returns at the edge where the transfer happened.
	task automatic send_item(logic fn, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] bp,
			logic [DATA_W-1:0] val, logic [DATA_W-1:0] smp, bit typed,
			logic [DATA_W-1:0] exp_val);
		int gap;
		if (burst_left == 0) begin
			// idle stretch between bursts, sometimes none at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid         <= 1'b1;
		func             <= fn;
		entry_index      <= idx;
		entry_breakpoint <= bp;
		entry_value      <= val;
		sample           <= smp;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		if (fn == FUNC_LOOKUP) begin
			pending_results.push_back(typed ? exp_val : map_sample(smp));
		end else begin
			bp_mem[idx]  = bp;
			val_mem[idx] = val;
		end
	endtask

	task automatic load_entry(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] bp,
			logic [DATA_W-1:0] val);
		send_item(FUNC_LOAD, idx, bp, val, $urandom(), 1'b0, '0);
	endtask

	task automatic lookup(logic [DATA_W-1:0] smp);
		send_item(FUNC_LOOKUP, IDX_W'($urandom()), $urandom(), $urandom(), smp, 1'b0, '0);
	endtask

	// Drain all results and let trailing loads leave the pipe, then write.
	task automatic write_reg(cfg_reg_t sel, logic [DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (sel)
			REG_OOR_MODE:    oor_sel    = data[MODE_W-1:0];
			REG_INTERP_MODE: interp_sel = data[MODE_W-1:0];
			REG_LOW_FILL:    fill_lo    = data;
			REG_HIGH_FILL:   fill_hi    = data;
			REG_ENTRIES:     entry_cnt  = data[NIN_W-1:0];
			REG_USE_BP:      bp_search  = data[0];
			default: ;
		endcase
	endtask

	function automatic logic [DATA_W-1:0] clip32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[DATA_W-1:0];
	endfunction

	// Load a non-decreasing breakpoint run over the active entries.
	task automatic load_sorted_table(int n);
		longint b;
		int span;
		span = ($urandom_range(0, 3) == 0) ? 23 : $urandom_range(4, 20);
		b    = -longint'($urandom_range(0, 1 << 20)) * n;
		for (int i = 0; i < n; i++) begin
			load_entry(IDX_W'(i), clip32(b), $urandom());
			// occasional repeated breakpoint
			b = b + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << span));
		end
	endtask

	// Pick a sample: mostly inside the table range, some at and past its ends.
	function automatic logic [DATA_W-1:0] pick_sample();
		longint lo, hi;
		int last, pick;
		last = active_entries() - 1;
		lo   = bp_search ? longint'(bp_mem[0]) : 0;
		hi   = bp_search ? longint'(bp_mem[last]) : longint'(last) * 65536;
		pick = $urandom_range(0, 99);
		if (pick < 60 && hi >= lo)
			return clip32(lo + longint'({$urandom(), $urandom()} % (hi - lo + 1)));
		if (pick < 75) begin
			case ($urandom_range(0, 3))
				0: return clip32(lo - 1);
				1: return clip32(lo);
				2: return clip32(hi);
				default: return clip32(hi + 1);
			endcase
		end
		if (pick < 85)
			return bp_search ? bp_mem[$urandom_range(0, last)]
				: DATA_W'($urandom_range(0, last)) << 16;
		return $urandom();
	endfunction

	// --- receiver: stall pattern plus one long hold-off ----------------------
	initial begin
		int mode;
		bit held;
		held      = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= 50 && in_valid) begin
				// hold off long enough for the pipe to fill and stall the input
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(8, 64)) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// --- result checker -----------------------------------------------------
	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result_value: none expected, actual %h", result_value);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want) begin
					$error("result_value: expected %h, actual %h", want, result_value);
					errors++;
				end
			end
		end
	end

	// --- watchdog: cycles without any transfer ------------------------------
	always @(posedge clk) begin
		int quiet;
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
		else quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// --- main sequence ------------------------------------------------------
	initial begin
		dir_row_t rows[$];
		int n;
		errors           = 0;
		results_seen     = 0;
		burst_left       = 0;
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		func             <= FUNC_LOAD;
		entry_index      <= '0;
		entry_breakpoint <= '0;
		entry_value      <= '0;
		sample           <= '0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_OOR_MODE;
		cfg_wdata        <= '0;
		oor_sel    = OOR_CLAMP;
		interp_sel = INTERP_LINEAR;
		fill_lo    = '0;
		fill_hi    = '0;
		entry_cnt  = NIN_W'(TABLE_DEPTH);
		bp_search  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write every entry once so no lookup reads an unloaded entry
		for (int i = 0; i < TABLE_DEPTH; i++) load_entry(IDX_W'(i), i << 16, $urandom());

		// fill and pass-through at the extremes, then interpolation corners, unused mode codes and entry counts
		rows = '{
			'{ROW_CFG,  REG_OOR_MODE,    OOR_FILL,     0, 0, 0, 0},
			'{ROW_CFG,  REG_LOW_FILL,    32'h80000000, 0, 0, 0, 0},
			'{ROW_CFG,  REG_HIGH_FILL,   32'h7FFFFFFF, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h80000000, 0, 0, 1, 32'h80000000},
			'{ROW_LOOK, REG_OOR_MODE,    32'hFFFFFFFF, 0, 0, 1, 32'h80000000},
			'{ROW_LOOK, REG_OOR_MODE,    32'h7FFFFFFF, 0, 0, 1, 32'h7FFFFFFF},
			'{ROW_CFG,  REG_OOR_MODE,    OOR_PASS,     0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h7FFFFFFF, 0, 0, 1, 32'h7FFFFFFF},
			'{ROW_LOOK, REG_OOR_MODE,    32'hFFFF0000, 0, 0, 1, 32'hFFFF0000},
			'{ROW_CFG,  REG_OOR_MODE,    OOR_UNUSED,   0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'hFFFFFFFF, 0, 0, 0, 0},
			'{ROW_LOAD, REG_OOR_MODE,    32'h80000000, 0, 32'h7FFFFFFF, 0, 0},
			'{ROW_LOAD, REG_OOR_MODE,    32'h00000000, 1, 32'h80000000, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00008000, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h0000FFFF, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00010000, 0, 0, 0, 0},
			'{ROW_CFG,  REG_INTERP_MODE, INTERP_NEAREST, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00008000, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00FF0000, 0, 0, 0, 0},
			'{ROW_CFG,  REG_INTERP_MODE, INTERP_UNUSED, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h0001FFFF, 0, 0, 0, 0},
			'{ROW_CFG,  REG_ENTRIES,     32'd0,        0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00000005, 0, 0, 0, 0},
			'{ROW_CFG,  REG_ENTRIES,     32'd511,      0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00FF0000, 0, 0, 0, 0},
			// unsorted breakpoints: entry 2 below entry 1
			'{ROW_CFG,  REG_ENTRIES,     32'd3,        0, 0, 0, 0},
			'{ROW_CFG,  REG_INTERP_MODE, INTERP_LINEAR, 0, 0, 0, 0},
			'{ROW_CFG,  REG_USE_BP,      32'd1,        0, 0, 0, 0},
			'{ROW_LOAD, REG_OOR_MODE,    32'h00050000, 1, 32'h00001000, 0, 0},
			'{ROW_LOAD, REG_OOR_MODE,    32'h00030000, 2, 32'h00002000, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00020000, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00040000, 0, 0, 0, 0},
			'{ROW_LOOK, REG_OOR_MODE,    32'h00050000, 0, 0, 0, 0}
		};
		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_CFG:  write_reg(rows[i].reg_sel, rows[i].data);
				ROW_LOAD: load_entry(rows[i].idx, rows[i].data, rows[i].val);
				default:  send_item(FUNC_LOOKUP, IDX_W'($urandom()), $urandom(), $urandom(),
						rows[i].data, rows[i].typed, rows[i].exp_val);
			endcase
		end

		// random phases, first ones pinned to the entry-count extremes
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: n = TABLE_DEPTH;
				1: n = 1;
				2: n = 0;
				3: n = 300 + $urandom_range(0, 211);
				default: n = ($urandom_range(0, 5) == 0) ? TABLE_DEPTH : $urandom_range(2, 16);
			endcase
			write_reg(REG_ENTRIES, n);
			write_reg(REG_OOR_MODE, $urandom_range(0, 3));
			write_reg(REG_INTERP_MODE, $urandom_range(0, 3));
			write_reg(REG_LOW_FILL, $urandom());
			write_reg(REG_HIGH_FILL, $urandom());
			write_reg(REG_USE_BP, DATA_W'(p % 2 == 1));
			if (bp_search && $urandom_range(0, 4) != 0) load_sorted_table(active_entries());
			for (int i = 0; i < PHASE_LOOKUPS; i++) begin
				// stray loads, which may leave the breakpoints unsorted
				if ($urandom_range(0, 9) == 0)
					load_entry(IDX_W'($urandom()), $urandom(), $urandom());
				lookup(pick_sample());
			end
		end

		// drain, let the pipe settle, then report
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/blint_pkg.sv
rtl/blint_ram.sv
rtl/blint_level.sv
rtl/blint_div.sv
rtl/breakpoint_lut_interpolator.sv
dv/tb_breakpoint_lut_interpolator.sv
